@@ hw/rtl/rgbsd_pkg.sv @@
// rgbsd_pkg: shared types and constants of the rgb led matrix scan driver
// no dependencies; used by the interfaces, the controller, the datapath and the top level
`default_nettype none

package rgbsd_pkg;

    // command opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // color phases of one row pair, and the closing phase of a frame
    localparam logic [1:0] PHASE_RED   = 2'd0;
    localparam logic [1:0] PHASE_GREEN = 2'd1;
    localparam logic [1:0] PHASE_BLUE  = 2'd2;
    localparam logic [1:0] PHASE_FIX   = 2'd3;

    // latch sequence steps after the shift steps
    localparam logic [1:0] LATCH_BLANK   = 2'd0;
    localparam logic [1:0] LATCH_STROBE  = 2'd1;
    localparam logic [1:0] LATCH_ADDR    = 2'd2;
    localparam logic [1:0] LATCH_UNBLANK = 2'd3;

    // bit positions of a frame store word
    localparam int PLANE_RED   = 0;
    localparam int PLANE_GREEN = 1;
    localparam int PLANE_BLUE  = 2;
    localparam int PLANE_BITS  = 3;

    typedef struct packed {
        logic       opcode;
        logic [4:0] pixel_row;
        logic [5:0] pixel_col;
        logic       red_on;
        logic       green_on;
        logic       blue_on;
    } cmd_beat_t;

    typedef struct packed {
        logic       shift_clock;
        logic       red_top;
        logic       red_bottom;
        logic       green_top;
        logic       green_bottom;
        logic       blue_top;
        logic       blue_bottom;
        logic [3:0] row_address;
        logic       output_enable_n;
        logic       latch_strobe;
        logic       frame_end;
    } pin_beat_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } ctrl_state_t;

    typedef struct packed {
        logic clear_en;
        logic accept;
        logic exec;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/rgbsd_if.sv @@
// rgbsd_cmd_if and rgbsd_pin_if: valid/ready channels of the scan driver
// depends on rgbsd_pkg for the beat types
`default_nettype none

interface rgbsd_cmd_if;
    logic                 valid;
    logic                 ready;
    rgbsd_pkg::cmd_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rgbsd_pin_if;
    logic                 valid;
    logic                 ready;
    rgbsd_pkg::pin_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/rgb_led_matrix_scan_driver_unit.sv @@
// a pixel write is taken in the idle state; a tick moves the controller to its execute
// state, which registers the pin snapshot once the output register is free
// cmd.ready is low until then; the tick rate is set by these states and by pins.ready
// reset: scan state to row 0 red phase, pins low with output enable high,
// then a pass that clears all 2*SCAN_ROWS*PANEL_COLUMNS words (2048 by default), cmd.ready low
`default_nettype none

module rgb_led_matrix_scan_driver_unit #(
    parameter int PANEL_COLUMNS = 64,
    parameter int SCAN_ROWS     = 16
) (
    input wire logic     clk,
    input wire logic     rst_n,
    rgbsd_cmd_if.sink    cmd,
    rgbsd_pin_if.source  pins
);

    // control and status between the state machine and the datapath
    rgbsd_pkg::ctrl_cmd_t  ctrl;
    rgbsd_pkg::dp_status_t status;

    // controller: clear sweep after reset, then idle taking beats,
    // and for a tick an execute state that waits for a free output register
    rgbsd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd.valid),
        .cmd_opcode (cmd.data.opcode),
        .cmd_ready  (cmd.ready),
        .status     (status),
        .ctrl       (ctrl)
    );

    // datapath: frame store with two read ports for the top and bottom rows,
    // scan counters, and the pin image that doubles as the output register
    rgbsd_datapath #(
        .PANEL_COLUMNS (PANEL_COLUMNS),
        .SCAN_ROWS     (SCAN_ROWS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .status    (status),
        .cmd_data  (cmd.data),
        .out_valid (pins.valid),
        .out_ready (pins.ready),
        .out_data  (pins.data)
    );

endmodule

`default_nettype wire

@@ hw/rtl/rgbsd_ctrl.sv @@
// rgbsd_ctrl: controller state machine of the scan driver
// depends on rgbsd_pkg for the state, command and status types
`default_nettype none

module rgbsd_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cmd_valid,
    input  wire logic                   cmd_opcode,
    output logic                        cmd_ready,
    input  wire rgbsd_pkg::dp_status_t  status,
    output rgbsd_pkg::ctrl_cmd_t        ctrl
);

    rgbsd_pkg::ctrl_state_t state_reg;
    rgbsd_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rgbsd_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rgbsd_pkg::ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = rgbsd_pkg::ST_IDLE;
                end
            end
            rgbsd_pkg::ST_IDLE:
            begin
                if (cmd_valid && cmd_opcode == rgbsd_pkg::OP_TICK)
                begin
                    state_next = rgbsd_pkg::ST_EXEC;
                end
            end
            rgbsd_pkg::ST_EXEC:
            begin
                if (status.out_free)
                begin
                    state_next = rgbsd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rgbsd_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd_ready     = 1'b0;
        ctrl.clear_en = 1'b0;
        ctrl.accept   = 1'b0;
        ctrl.exec     = 1'b0;
        unique case (state_reg)
            rgbsd_pkg::ST_CLEAR:
            begin
                ctrl.clear_en = 1'b1;
            end
            rgbsd_pkg::ST_IDLE:
            begin
                cmd_ready   = 1'b1;
                ctrl.accept = cmd_valid;
            end
            rgbsd_pkg::ST_EXEC:
            begin
                ctrl.exec = status.out_free;
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/rgbsd_frame_store.sv @@
// rgbsd_frame_store: one write port, two registered read ports, three color bits a word
// depends on rgbsd_pkg for the word width
`default_nettype none

module rgbsd_frame_store #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [AW-1:0]                    waddr,
    input  wire logic [rgbsd_pkg::PLANE_BITS-1:0] wdata,
    input  wire logic [AW-1:0]                    raddr_a,
    input  wire logic [AW-1:0]                    raddr_b,
    output logic      [rgbsd_pkg::PLANE_BITS-1:0] rdata_a,
    output logic      [rgbsd_pkg::PLANE_BITS-1:0] rdata_b
);

    logic [rgbsd_pkg::PLANE_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

@@ hw/rtl/rgbsd_datapath.sv @@
// rgbsd_datapath: frame store, scan counters, pin image and output register
// depends on rgbsd_pkg and rgbsd_frame_store
`default_nettype none

module rgbsd_datapath #(
    parameter int PANEL_COLUMNS = 64,
    parameter int SCAN_ROWS     = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire rgbsd_pkg::ctrl_cmd_t  ctrl,
    output rgbsd_pkg::dp_status_t      status,
    input  wire rgbsd_pkg::cmd_beat_t  cmd_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output rgbsd_pkg::pin_beat_t       out_data
);

    localparam int DEPTH       = 2 * SCAN_ROWS * PANEL_COLUMNS;
    localparam int AW          = $clog2(DEPTH);
    localparam int SRW         = $clog2(SCAN_ROWS);
    localparam int CW          = $clog2(PANEL_COLUMNS);
    localparam int STW         = $clog2(2 * PANEL_COLUMNS + 4);
    localparam logic [STW-1:0] SHIFT_STEPS = STW'(2 * PANEL_COLUMNS);
    localparam logic [SRW-1:0] LAST_ROW    = SRW'(SCAN_ROWS - 1);
    localparam logic [AW-1:0]  LAST_ADDR   = AW'(DEPTH - 1);
    localparam logic [6:0]     ROW_LIMIT   = 7'(2 * SCAN_ROWS);
    localparam logic [8:0]     COL_LIMIT   = 9'(PANEL_COLUMNS);

    logic [AW-1:0]        clear_addr_reg;
    logic [AW-1:0]        clear_addr_next;
    logic [SRW-1:0]       scan_row_reg;
    logic [SRW-1:0]       scan_row_next;
    logic [1:0]           phase_reg;
    logic [1:0]           phase_next;
    logic [STW-1:0]       step_reg;
    logic [STW-1:0]       step_next;
    rgbsd_pkg::pin_beat_t pin_reg;
    rgbsd_pkg::pin_beat_t pin_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;

    logic                 shifting;
    logic [CW-1:0]        col;
    logic [STW-1:0]       latch_full;
    logic [1:0]           latch_step;
    logic [AW-1:0]        top_addr;
    logic [AW-1:0]        bot_addr;
    logic [AW-1:0]        pix_addr;
    logic                 pix_in_range;
    logic                 we;
    logic [AW-1:0]        waddr;
    logic [rgbsd_pkg::PLANE_BITS-1:0] wdata;
    logic [rgbsd_pkg::PLANE_BITS-1:0] rd_top;
    logic [rgbsd_pkg::PLANE_BITS-1:0] rd_bot;
    logic                 bit_top;
    logic                 bit_bot;
    logic                 phase_done;

    // read addresses follow the scan state, stable while a tick is in flight
    assign shifting   = step_reg < SHIFT_STEPS;
    assign col        = shifting ? step_reg[CW:1] : '0;
    assign top_addr   = AW'(32'(scan_row_reg) * PANEL_COLUMNS + 32'(col));
    assign bot_addr   = AW'((32'(scan_row_reg) + SCAN_ROWS) * PANEL_COLUMNS + 32'(col));
    assign latch_full = step_reg - SHIFT_STEPS;
    assign latch_step = latch_full[1:0];

    assign pix_in_range = ({2'b00, cmd_data.pixel_row} < ROW_LIMIT)
                       && ({3'b000, cmd_data.pixel_col} < COL_LIMIT);
    assign pix_addr     = AW'(32'(cmd_data.pixel_row) * PANEL_COLUMNS
                              + 32'(cmd_data.pixel_col));

    always_comb
    begin
        if (ctrl.clear_en)
        begin
            we    = 1'b1;
            waddr = clear_addr_reg;
            wdata = '0;
        end
        else
        begin
            we    = ctrl.accept && cmd_data.opcode == rgbsd_pkg::OP_WRITE && pix_in_range;
            waddr = pix_addr;
            wdata = {cmd_data.blue_on, cmd_data.green_on, cmd_data.red_on};
        end
    end

    rgbsd_frame_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (top_addr),
        .raddr_b (bot_addr),
        .rdata_a (rd_top),
        .rdata_b (rd_bot)
    );

    always_comb
    begin
        case (phase_reg)
            rgbsd_pkg::PHASE_RED:
            begin
                bit_top = rd_top[rgbsd_pkg::PLANE_RED];
                bit_bot = rd_bot[rgbsd_pkg::PLANE_RED];
            end
            rgbsd_pkg::PHASE_GREEN:
            begin
                bit_top = rd_top[rgbsd_pkg::PLANE_GREEN];
                bit_bot = rd_bot[rgbsd_pkg::PLANE_GREEN];
            end
            default:
            begin
                bit_top = rd_top[rgbsd_pkg::PLANE_BLUE];
                bit_bot = rd_bot[rgbsd_pkg::PLANE_BLUE];
            end
        endcase
    end

    always_comb
    begin
        clear_addr_next = clear_addr_reg;
        scan_row_next   = scan_row_reg;
        phase_next      = phase_reg;
        step_next       = step_reg;
        pin_next        = pin_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        phase_done      = 1'b0;

        if (ctrl.clear_en)
        begin
            clear_addr_next = clear_addr_reg + 1'b1;
        end

        if (ctrl.exec)
        begin
            pin_next.frame_end = 1'b0;
            if (shifting)
            begin
                pin_next.shift_clock  = step_reg[0];
                pin_next.red_top      = 1'b0;
                pin_next.red_bottom   = 1'b0;
                pin_next.green_top    = 1'b0;
                pin_next.green_bottom = 1'b0;
                pin_next.blue_top     = 1'b0;
                pin_next.blue_bottom  = 1'b0;
                case (phase_reg)
                    rgbsd_pkg::PHASE_RED:
                    begin
                        pin_next.red_top    = bit_top;
                        pin_next.red_bottom = bit_bot;
                    end
                    rgbsd_pkg::PHASE_GREEN:
                    begin
                        pin_next.green_top    = bit_top;
                        pin_next.green_bottom = bit_bot;
                    end
                    default:
                    begin
                        pin_next.blue_top    = bit_top;
                        pin_next.blue_bottom = bit_bot;
                    end
                endcase
            end
            else if (phase_reg == rgbsd_pkg::PHASE_FIX)
            begin
                pin_next.output_enable_n = 1'b1;
                pin_next.frame_end       = 1'b1;
                phase_done               = 1'b1;
            end
            else
            begin
                unique case (latch_step)
                    rgbsd_pkg::LATCH_BLANK:
                    begin
                        pin_next.output_enable_n = 1'b1;
                    end
                    rgbsd_pkg::LATCH_STROBE:
                    begin
                        pin_next.latch_strobe = 1'b1;
                    end
                    rgbsd_pkg::LATCH_ADDR:
                    begin
                        pin_next.latch_strobe = 1'b0;
                        pin_next.row_address  = 4'(scan_row_reg);
                    end
                    rgbsd_pkg::LATCH_UNBLANK:
                    begin
                        pin_next.output_enable_n = 1'b0;
                        phase_done               = 1'b1;
                    end
                endcase
            end

            if (phase_done)
            begin
                step_next = '0;
                if (phase_reg == rgbsd_pkg::PHASE_FIX)
                begin
                    scan_row_next = '0;
                    phase_next    = rgbsd_pkg::PHASE_RED;
                end
                else if (phase_reg != rgbsd_pkg::PHASE_BLUE)
                begin
                    phase_next = phase_reg + 1'b1;
                end
                else if (scan_row_reg == LAST_ROW)
                begin
                    phase_next = rgbsd_pkg::PHASE_FIX;
                end
                else
                begin
                    scan_row_next = scan_row_reg + 1'b1;
                    phase_next    = rgbsd_pkg::PHASE_RED;
                end
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end

            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_addr_reg <= '0;
            scan_row_reg   <= '0;
            phase_reg      <= rgbsd_pkg::PHASE_RED;
            step_reg       <= '0;
            pin_reg        <= '{output_enable_n: 1'b1, default: '0};
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            clear_addr_reg <= clear_addr_next;
            scan_row_reg   <= scan_row_next;
            phase_reg      <= phase_next;
            step_reg       <= step_next;
            pin_reg        <= pin_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign status.clear_last = clear_addr_reg == LAST_ADDR;
    assign status.out_free   = !out_valid_reg || out_ready;
    assign out_valid         = out_valid_reg;
    assign out_data          = pin_reg;

endmodule

`default_nettype wire
